[sv/ghl_pkg.sv]
// -----------------------------------------------------------------------------
// ghl_pkg: shared definitions for the grid height lookup block
// Field widths, op codes, command kinds and parameter defaults.
// -----------------------------------------------------------------------------
package ghl_pkg;

    localparam int COORD_W          = 6;
    localparam int OP_W             = 2;
    localparam int CFG_W            = 2;
    localparam int QUEUE_DEPTH      = 2;

    localparam int GRID_SIZE_DEF    = 64;
    localparam int MAX_RADIUS_DEF   = 2;
    localparam int HEIGHT_BITS_DEF  = 20;

    localparam logic [OP_W-1:0]  OP_LOAD         = 2'd0;
    localparam logic [OP_W-1:0]  OP_QUERY        = 2'd1;
    localparam logic [OP_W-1:0]  OP_CLEAR        = 2'd2;
    localparam logic [CFG_W-1:0] FILL_RADIUS_RST = 2'd1;

    typedef enum logic [1:0] {
        K_LOAD  = 2'd0,
        K_QUERY = 2'd1,
        K_CLEAR = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [COORD_W-1:0] u;
        logic [COORD_W-1:0] v;
    } t_cmd;

endpackage

[sv/ghl_ifs.sv]
// -----------------------------------------------------------------------------
// ghl_in_if / ghl_out_if: valid/ready channels of the grid height lookup
// One beat moves one command in, or one lookup result out.
// -----------------------------------------------------------------------------
interface ghl_in_if import ghl_pkg::*; #(
    parameter int HEIGHT_BITS = HEIGHT_BITS_DEF
) ();
    logic                          valid;
    logic                          ready;
    logic [OP_W-1:0]               op;
    logic [COORD_W-1:0]            cell_u;
    logic [COORD_W-1:0]            cell_v;
    logic signed [HEIGHT_BITS-1:0] height;

    modport source (output valid, op, cell_u, cell_v, height, input ready);
    modport sink   (input valid, op, cell_u, cell_v, height, output ready);
endinterface

interface ghl_out_if import ghl_pkg::*; #(
    parameter int HEIGHT_BITS = HEIGHT_BITS_DEF
) ();
    logic                          valid;
    logic                          ready;
    logic                          found;
    logic signed [HEIGHT_BITS-1:0] baseline_height;

    modport source (output valid, found, baseline_height, input ready);
    modport sink   (input valid, found, baseline_height, output ready);
endinterface

[sv/ghl_ram.sv]
// -----------------------------------------------------------------------------
// ghl_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// -----------------------------------------------------------------------------
module ghl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[sv/ghl_front.sv]
// -----------------------------------------------------------------------------
// ghl_front: command intake and classification
// Decodes the op, drops unknown ops and off-grid loads, and pushes the rest.
// -----------------------------------------------------------------------------
module ghl_front import ghl_pkg::*; #(
    parameter int GRID_SIZE   = GRID_SIZE_DEF,
    parameter int HEIGHT_BITS = HEIGHT_BITS_DEF
) (
    ghl_in_if.sink                 i_in,
    input  logic                   i_init_done,
    input  logic                   i_q_full,
    output logic                   o_push,
    output t_cmd                   o_cmd,
    output logic [HEIGHT_BITS-1:0] o_height
);
    logic on_grid;
    logic keep;

    assign on_grid = (32'(i_in.cell_u) < 32'(GRID_SIZE))
                  && (32'(i_in.cell_v) < 32'(GRID_SIZE));

    always_comb begin
        o_cmd.u    = i_in.cell_u;
        o_cmd.v    = i_in.cell_v;
        o_cmd.kind = K_QUERY;
        keep       = 1'b0;
        case (i_in.op)
            OP_LOAD: begin
                o_cmd.kind = K_LOAD;
                keep       = on_grid;
            end
            OP_QUERY: begin
                o_cmd.kind = K_QUERY;
                keep       = 1'b1;
            end
            OP_CLEAR: begin
                o_cmd.kind = K_CLEAR;
                keep       = 1'b1;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign i_in.ready = i_init_done && !i_q_full;
    assign o_push     = i_in.valid && i_in.ready && keep;
    assign o_height   = i_in.height;
endmodule

[sv/ghl_queue.sv]
// -----------------------------------------------------------------------------
// ghl_queue: short command queue between intake and execution
// A small FIFO so that intake and execution stall independently.
// -----------------------------------------------------------------------------
module ghl_queue import ghl_pkg::*; #(
    parameter int HEIGHT_BITS = HEIGHT_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  t_cmd                   i_cmd,
    input  logic [HEIGHT_BITS-1:0] i_height,
    output logic                   o_full,
    output logic                   o_valid,
    output t_cmd                   o_cmd,
    output logic [HEIGHT_BITS-1:0] o_height,
    input  logic                   i_pop
);
    localparam int PW = $clog2(QUEUE_DEPTH);

    t_cmd                   r_cmd    [QUEUE_DEPTH];
    logic [HEIGHT_BITS-1:0] r_height [QUEUE_DEPTH];
    logic [PW-1:0]          r_wptr;
    logic [PW-1:0]          r_rptr;
    logic [PW:0]            r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_cmd[r_wptr]    <= i_cmd;
                r_height[r_wptr] <= i_height;
                r_wptr           <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_full   = (r_count == (PW+1)'(QUEUE_DEPTH));
    assign o_valid  = (r_count != '0);
    assign o_cmd    = r_cmd[r_rptr];
    assign o_height = r_height[r_rptr];
endmodule

[sv/ghl_back.sv]
// -----------------------------------------------------------------------------
// ghl_back: command execution over the height grid
// Loads, clears and queries the grid RAM; a query scans the square around the
// cell once and picks the median of the innermost ring that holds valid cells.
// -----------------------------------------------------------------------------
module ghl_back import ghl_pkg::*; #(
    parameter int GRID_SIZE   = GRID_SIZE_DEF,
    parameter int MAX_RADIUS  = MAX_RADIUS_DEF,
    parameter int HEIGHT_BITS = HEIGHT_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [CFG_W-1:0]              i_fill_radius,
    input  logic                          i_q_valid,
    input  t_cmd                          i_q_cmd,
    input  logic [HEIGHT_BITS-1:0]        i_q_height,
    output logic                          o_q_pop,
    output logic                          o_init_done,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_out_found,
    output logic signed [HEIGHT_BITS-1:0] o_out_height
);
    localparam int CELLS = GRID_SIZE * GRID_SIZE;
    localparam int AW    = $clog2(CELLS);
    localparam int RW    = $clog2(MAX_RADIUS + 1);
    localparam int SW    = RW + 1;
    localparam int NW    = COORD_W + RW + 1;
    localparam int BUF_N = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
    localparam int BW    = $clog2(BUF_N + 1);
    localparam int BIW   = $clog2(BUF_N);
    localparam int HB    = HEIGHT_BITS;

    typedef enum logic [5:0] {
        S_INIT  = 6'b000001,
        S_IDLE  = 6'b000010,
        S_CLEAR = 6'b000100,
        S_SCAN  = 6'b001000,
        S_RANK  = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    function automatic logic signed [NW-1:0] f_pos(
        input logic [COORD_W-1:0] c,
        input logic [SW-1:0]      k,
        input logic [RW-1:0]      lim
    );
        return signed'(NW'(c)) + signed'(NW'(k)) - signed'(NW'(lim));
    endfunction

    function automatic logic [RW-1:0] f_dist(
        input logic [SW-1:0] k,
        input logic [RW-1:0] lim
    );
        logic signed [NW-1:0] d;
        d = signed'(NW'(k)) - signed'(NW'(lim));
        return d[NW-1] ? RW'(-d) : RW'(d);
    endfunction

    function automatic logic f_on(input logic signed [NW-1:0] p);
        return !p[NW-1] && (32'(p[NW-2:0]) < 32'(GRID_SIZE));
    endfunction

    function automatic logic [AW-1:0] f_addr(
        input logic [NW-2:0] u,
        input logic [NW-2:0] v
    );
        return AW'(v) * AW'(GRID_SIZE) + AW'(u);
    endfunction

    t_state                 r_state;
    logic [AW-1:0]          r_sw;
    logic [COORD_W-1:0]     r_u;
    logic [COORD_W-1:0]     r_v;
    logic [RW-1:0]          r_lim;
    logic [SW-1:0]          r_du_c;
    logic [SW-1:0]          r_dv_c;
    logic                   r_issue_done;
    logic                   r_p_valid;
    logic                   r_p_on;
    logic [RW-1:0]          r_p_ring;
    logic signed [HB-1:0]   r_buf  [BUF_N];
    logic [RW-1:0]          r_ring [BUF_N];
    logic [BW-1:0]          r_n;
    logic [BW-1:0]          r_m;
    logic [RW-1:0]          r_minr;
    logic [BW-1:0]          r_idx;
    logic                   r_a_valid;
    logic                   r_a_last;
    logic                   r_a_ok;
    logic signed [HB-1:0]   r_a_cand;
    logic [BUF_N-1:0]       r_lt;
    logic [BUF_N-1:0]       r_le;
    logic signed [HB-1:0]   r_lo;
    logic signed [HB-1:0]   r_hi;
    logic                   r_res_found;
    logic                   r_out_valid;
    logic                   r_found;
    logic signed [HB-1:0]   r_height;

    logic [RW-1:0]          lim;
    logic signed [NW-1:0]   scan_nu;
    logic signed [NW-1:0]   scan_nv;
    logic [RW-1:0]          ring_u;
    logic [RW-1:0]          ring_v;
    logic [RW-1:0]          scan_ring;
    logic                   scan_on;
    logic [AW-1:0]          scan_addr;
    logic [SW-1:0]          span;
    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [HB:0]            ram_wdata;
    logic [HB:0]            ram_rdata;
    logic signed [HB-1:0]   cand;
    logic                   elig [BUF_N];
    logic [BUF_N-1:0]       lt_vec;
    logic [BUF_N-1:0]       le_vec;
    logic [BW-1:0]          cnt_lt;
    logic [BW-1:0]          cnt_le;
    logic [BW-1:0]          k_lo;
    logic [BW-1:0]          k_hi;
    logic signed [HB:0]     med_sum;
    logic                   out_free;

    assign lim = (32'(i_fill_radius) > 32'(MAX_RADIUS)) ? RW'(MAX_RADIUS)
                                                        : RW'(i_fill_radius);

    // Scan address generation for the square around the queried cell.
    assign span      = {r_lim, 1'b0};
    assign scan_nu   = f_pos(r_u, r_du_c, r_lim);
    assign scan_nv   = f_pos(r_v, r_dv_c, r_lim);
    assign ring_u    = f_dist(r_du_c, r_lim);
    assign ring_v    = f_dist(r_dv_c, r_lim);
    assign scan_ring = (ring_u > ring_v) ? ring_u : ring_v;
    assign scan_on   = f_on(scan_nu) && f_on(scan_nv);
    assign scan_addr = f_addr(scan_nu[NW-2:0], scan_nv[NW-2:0]);

    assign o_q_pop   = (r_state == S_IDLE) && i_q_valid;

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_sw;
        ram_wdata = '0;
        if (r_state == S_INIT || r_state == S_CLEAR) begin
            ram_we = 1'b1;
        end else if (o_q_pop && i_q_cmd.kind == K_LOAD) begin
            ram_we    = 1'b1;
            ram_waddr = f_addr((NW-1)'(i_q_cmd.u), (NW-1)'(i_q_cmd.v));
            ram_wdata = {1'b1, i_q_height};
        end
    end

    ghl_ram #(
        .WIDTH (HB + 1),
        .DEPTH (CELLS)
    ) u_grid_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (scan_addr),
        .o_rdata (ram_rdata)
    );

    // Rank of the current candidate among entries of the innermost ring.
    always_comb begin
        cand = r_buf[r_idx[BIW-1:0]];
        for (int j = 0; j < BUF_N; j++) begin
            elig[j]   = (BW'(j) < r_n) && (r_ring[j] == r_minr);
            lt_vec[j] = elig[j] && (r_buf[j] < cand);
            le_vec[j] = elig[j] && (r_buf[j] <= cand);
        end
    end

    assign cnt_lt   = BW'($countones(r_lt));
    assign cnt_le   = BW'($countones(r_le));
    assign k_lo     = (r_m - 1'b1) >> 1;
    assign k_hi     = r_m >> 1;
    assign med_sum  = {r_lo[HB-1], r_lo} + {r_hi[HB-1], r_hi};
    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_sw        <= '0;
            r_p_valid   <= 1'b0;
            r_a_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // In S_DONE the output register is either reloaded or held.
            if (r_out_valid && i_out_ready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_INIT, S_CLEAR: begin
                    r_sw <= r_sw + 1'b1;
                    if (r_sw == AW'(CELLS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (o_q_pop) begin
                        case (i_q_cmd.kind)
                            K_QUERY: begin
                                r_u          <= i_q_cmd.u;
                                r_v          <= i_q_cmd.v;
                                r_lim        <= lim;
                                r_du_c       <= '0;
                                r_dv_c       <= '0;
                                r_issue_done <= 1'b0;
                                r_p_valid    <= 1'b0;
                                r_n          <= '0;
                                r_m          <= '0;
                                r_state      <= S_SCAN;
                            end
                            K_CLEAR: begin
                                r_sw    <= '0;
                                r_state <= S_CLEAR;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    r_p_valid <= !r_issue_done;
                    r_p_on    <= scan_on;
                    r_p_ring  <= scan_ring;
                    if (!r_issue_done) begin
                        if (r_dv_c == span) begin
                            r_dv_c <= '0;
                            if (r_du_c == span) begin
                                r_issue_done <= 1'b1;
                            end else begin
                                r_du_c <= r_du_c + 1'b1;
                            end
                        end else begin
                            r_dv_c <= r_dv_c + 1'b1;
                        end
                    end
                    if (r_p_valid && r_p_on && ram_rdata[HB]) begin
                        r_buf[r_n[BIW-1:0]]  <= ram_rdata[HB-1:0];
                        r_ring[r_n[BIW-1:0]] <= r_p_ring;
                        r_n                  <= r_n + 1'b1;
                        if (r_m == '0 || r_p_ring < r_minr) begin
                            r_minr <= r_p_ring;
                            r_m    <= BW'(1);
                        end else if (r_p_ring == r_minr) begin
                            r_m <= r_m + 1'b1;
                        end
                    end
                    if (r_issue_done && !r_p_valid) begin
                        if (r_m == '0) begin
                            r_res_found <= 1'b0;
                            r_state     <= S_DONE;
                        end else begin
                            r_idx     <= '0;
                            r_a_valid <= 1'b0;
                            r_state   <= S_RANK;
                        end
                    end
                end
                S_RANK: begin
                    // Stage one compares a candidate with every entry,
                    // stage two counts and checks the two middle ranks.
                    // When the last candidate reaches stage two, r_idx has
                    // already run up to r_n, so stage one goes idle.
                    r_a_valid <= (r_idx < r_n);
                    r_a_last  <= (r_idx == r_n - 1'b1);
                    r_a_ok    <= (r_ring[r_idx[BIW-1:0]] == r_minr);
                    r_a_cand  <= cand;
                    r_lt      <= lt_vec;
                    r_le      <= le_vec;
                    if (r_idx < r_n) begin
                        r_idx <= r_idx + 1'b1;
                    end
                    if (r_a_valid && r_a_ok) begin
                        if (cnt_lt <= k_lo && k_lo < cnt_le) begin
                            r_lo <= r_a_cand;
                        end
                        if (cnt_lt <= k_hi && k_hi < cnt_le) begin
                            r_hi <= r_a_cand;
                        end
                    end
                    if (r_a_valid && r_a_last) begin
                        r_res_found <= 1'b1;
                        r_state     <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_found     <= r_res_found;
                        r_height    <= r_res_found ? med_sum[HB:1] : '0;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_init_done  = (r_state != S_INIT);
    assign o_out_valid  = r_out_valid;
    assign o_out_found  = r_found;
    assign o_out_height = r_height;
endmodule

[sv/grid_height_lookup_median_fill.sv]
// -----------------------------------------------------------------------------
// grid_height_lookup_median_fill: height grid with neighbor median hole fill
// Loads, clears and queries a grid of heights; empty cells are filled with the
// median of the nearest ring of valid neighbors.
// -----------------------------------------------------------------------------
//  channel  | dir | beat carries                        | results
//  i_in     | in  | op, cell_u, cell_v, height          | query only
//  o_out    | out | found, baseline_height              | one per query
//  i_cfg_*  | in  | fill_radius write, no read-back     | none
//
//  After reset the grid RAM is cleared one cell per cycle with i_in.ready low.
//  A clear op repeats that pass in the execution unit. A load is one RAM write.
//  A query scans the (2L+1)^2 cells around the cell, L = min(fill_radius,
//  MAX_RADIUS), ranks the valid cells found and loads the median of the
//  innermost ring into the output register. A two-entry command queue keeps
//  intake running while o_out is stalled, until the queue is full.
// -----------------------------------------------------------------------------
module grid_height_lookup_median_fill import ghl_pkg::*; #(
    parameter int GRID_SIZE   = GRID_SIZE_DEF,
    parameter int MAX_RADIUS  = MAX_RADIUS_DEF,
    parameter int HEIGHT_BITS = HEIGHT_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_data,
    ghl_in_if.sink           i_in,
    ghl_out_if.source        o_out
);
    logic [CFG_W-1:0]       r_fill_radius;
    logic                   init_done;
    logic                   q_full;
    logic                   push;
    t_cmd                   push_cmd;
    logic [HEIGHT_BITS-1:0] push_height;
    logic                   q_valid;
    t_cmd                   q_cmd;
    logic [HEIGHT_BITS-1:0] q_height;
    logic                   q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill_radius <= FILL_RADIUS_RST;
        end else if (i_cfg_we) begin
            r_fill_radius <= i_cfg_data;
        end
    end

    ghl_front #(
        .GRID_SIZE   (GRID_SIZE),
        .HEIGHT_BITS (HEIGHT_BITS)
    ) u_front (
        .i_in        (i_in),
        .i_init_done (init_done),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_cmd       (push_cmd),
        .o_height    (push_height)
    );

    ghl_queue #(
        .HEIGHT_BITS (HEIGHT_BITS)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_cmd    (push_cmd),
        .i_height (push_height),
        .o_full   (q_full),
        .o_valid  (q_valid),
        .o_cmd    (q_cmd),
        .o_height (q_height),
        .i_pop    (q_pop)
    );

    ghl_back #(
        .GRID_SIZE   (GRID_SIZE),
        .MAX_RADIUS  (MAX_RADIUS),
        .HEIGHT_BITS (HEIGHT_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fill_radius (r_fill_radius),
        .i_q_valid     (q_valid),
        .i_q_cmd       (q_cmd),
        .i_q_height    (q_height),
        .o_q_pop       (q_pop),
        .o_init_done   (init_done),
        .o_out_valid   (o_out.valid),
        .i_out_ready   (o_out.ready),
        .o_out_found   (o_out.found),
        .o_out_height  (o_out.baseline_height)
    );
endmodule

[sv/ghl_checker.sv]
// -----------------------------------------------------------------------------
// ghl_checker: port-level checks for the grid height lookup
// Watches the channels of the top level and is bound to it.
// -----------------------------------------------------------------------------
module ghl_checker import ghl_pkg::*; #(
    parameter int HEIGHT_BITS = HEIGHT_BITS_DEF
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_in_valid,
    input logic                   i_in_ready,
    input logic [OP_W-1:0]        i_in_op,
    input logic                   i_out_valid,
    input logic                   i_out_ready,
    input logic                   i_found,
    input logic [HEIGHT_BITS-1:0] i_height
);
    logic [3:0] r_pend;
    logic       q_acc;
    logic       o_acc;

    assign q_acc = i_in_valid && i_in_ready && (i_in_op == OP_QUERY);
    assign o_acc = i_out_valid && i_out_ready;

    // Queries taken in but not yet answered.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else if (q_acc && !o_acc) begin
            r_pend <= r_pend + 1'b1;
        end else if (!q_acc && o_acc) begin
            r_pend <= r_pend - 1'b1;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result beat dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_found) && $stable(i_height))
        else $error("result payload changed while stalled");

    a_init_blocks: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_in_ready)
        else $error("input taken during the clearing pass after reset");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> r_pend != '0)
        else $error("result without an outstanding query");
endmodule

bind grid_height_lookup_median_fill ghl_checker #(
    .HEIGHT_BITS (HEIGHT_BITS)
) u_ghl_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_op     (i_in.op),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_found     (o_out.found),
    .i_height    (o_out.baseline_height)
);

[tb/testbench.sv]
// -----------------------------------------------------------------------------
// testbench: self-checking bench for the grid height lookup block
// Drives loads, clears, queries and unused ops with random idling on both channels and
// compares each lookup result against an internal model of the height grid.
// -----------------------------------------------------------------------------
module testbench;
    import ghl_pkg::*;

    localparam int GS    = GRID_SIZE_DEF;
    localparam int MAXR  = MAX_RADIUS_DEF;
    localparam int HB    = HEIGHT_BITS_DEF;
    localparam int LIMIT = 3000000;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic          found;
        logic [HB-1:0] height;
    } t_lookup;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_W-1:0] i_cfg_data;

    ghl_in_if  #(.HEIGHT_BITS(HB)) in_ch ();
    ghl_out_if #(.HEIGHT_BITS(HB)) out_ch ();

    grid_height_lookup_median_fill #(
        .GRID_SIZE(GS), .MAX_RADIUS(MAXR), .HEIGHT_BITS(HB)
    ) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_data(i_cfg_data), .i_in(in_ch.sink), .o_out(out_ch.source)
    );

    // Model state of the grid.
    logic signed [HB-1:0] grid_h [GS*GS];
    bit                   grid_ok [GS*GS];
    logic [CFG_W-1:0]     radius_reg;

    t_lookup lookups_due[$];
    int  errors;
    int  n_sent;
    int  n_seen;
    int  n_found;
    int  cycles;
    bit  calm;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic report(input string what);
        errors++;
        $display("mismatch %0d: %s", errors, what);
    endtask

    function automatic t_lookup lookup_height(input int u, input int v);
        t_lookup res;
        int lim, nn, i, j;
        logic signed [HB-1:0] vals [$];
        logic signed [HB-1:0] key;
        logic signed [HB:0]   s;
        res = '0;
        if (grid_ok[v*GS+u]) begin
            res.found = 1'b1;
            res.height = grid_h[v*GS+u];
            return res;
        end
        lim = (radius_reg > MAXR) ? MAXR : radius_reg;
        for (int r = 1; r <= lim; r++) begin
            vals.delete();
            for (int du = -r; du <= r; du++)
                for (int dv = -r; dv <= r; dv++)
                    if (u+du >= 0 && u+du < GS && v+dv >= 0 && v+dv < GS
                            && grid_ok[(v+dv)*GS+u+du])
                        vals = {vals, grid_h[(v+dv)*GS+u+du]};
            nn = vals.size();
            if (nn > 0) begin
                for (i = 1; i < nn; i++) begin
                    key = vals[i];
                    j = i - 1;
                    while (j >= 0 && vals[j] > key) begin
                        vals[j+1] = vals[j];
                        j--;
                    end
                    vals[j+1] = key;
                end
                res.found = 1'b1;
                if (nn % 2) begin
                    res.height = vals[nn/2];
                end else begin
                    // Arithmetic shift floors the mean toward minus infinity.
                    s = $signed({vals[nn/2-1][HB-1], vals[nn/2-1]})
                        + $signed({vals[nn/2][HB-1], vals[nn/2]});
                    res.height = s[HB:1];
                end
                return res;
            end
        end
        return res;
    endfunction

    task automatic idle_burst();
        if (!calm && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    // Valid stays high after a beat so the next beat can follow directly.
    task automatic send_cmd(input logic [OP_W-1:0] op, input int u, input int v,
                            input logic signed [HB-1:0] h);
        t_lookup res;
        idle_burst();
        in_ch.valid  <= 1'b1;
        in_ch.op     <= op;
        in_ch.cell_u <= u[COORD_W-1:0];
        in_ch.cell_v <= v[COORD_W-1:0];
        in_ch.height <= h;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        n_sent++;
        if (op == OP_LOAD) begin
            grid_h[v*GS+u] = h;
            grid_ok[v*GS+u] = 1'b1;
        end else if (op == OP_CLEAR) begin
            foreach (grid_ok[k]) grid_ok[k] = 1'b0;
        end else if (op == OP_QUERY) begin
            res = lookup_height(u, v);
            lookups_due = {lookups_due, res};
        end
    endtask

    // Result side: random stalls, then compare each beat with the oldest entry.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                t_lookup exp_r;
                n_seen++;
                if (lookups_due.size() == 0) begin
                    report("result with no query outstanding");
                end else begin
                    exp_r = lookups_due.pop_front();
                    if (exp_r.found) n_found++;
                    if (out_ch.found !== exp_r.found)
                        report($sformatf("found %b expected %b",
                                         out_ch.found, exp_r.found));
                    if (out_ch.baseline_height !== exp_r.height)
                        report($sformatf("height %0d expected %0d",
                                         out_ch.baseline_height,
                                         $signed(exp_r.height)));
                end
            end
            out_ch.ready <= calm ? 1'b1 : ($urandom_range(0, 4) != 0);
        end
    end

    // Waits out any clear pass still running before the register changes.
    task automatic write_radius(input logic [CFG_W-1:0] val);
        in_ch.valid <= 1'b0;
        while (lookups_due.size() != 0) @(posedge i_clk);
        repeat (GS*GS + 100) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        radius_reg = val;
    endtask

    function automatic logic signed [HB-1:0] rand_height();
        case ($urandom_range(0, 5))
            0: return {1'b1, {(HB-1){1'b0}}};
            1: return {1'b0, {(HB-1){1'b1}}};
            2: return HB'($signed($urandom_range(0, 200)) - 100);
            default: return HB'($urandom);
        endcase
    endfunction

    task automatic test_directed();
        send_cmd(OP_QUERY, 0, 0, '0);
        send_cmd(OP_LOAD, 0, 0, {1'b1, {(HB-1){1'b0}}});
        send_cmd(OP_LOAD, GS-1, GS-1, {1'b0, {(HB-1){1'b1}}});
        send_cmd(OP_QUERY, 0, 0, '0);
        send_cmd(OP_QUERY, GS-1, GS-1, '0);
        send_cmd(OP_QUERY, 1, 1, '0);
        send_cmd(OP_QUERY, GS-2, GS-1, '0);
        send_cmd(OP_LOAD, 2, 0, -20'sd5);
        send_cmd(OP_QUERY, 1, 0, '0);      // even count, floored mean
        send_cmd(OP_LOAD, 0, 2, 20'sd7);
        send_cmd(OP_QUERY, 1, 1, '0);      // odd count
        send_cmd(OP_UNUSED, 5, 5, '1);     // unused op, ignored
        send_cmd(OP_QUERY, 5, 5, '0);
        send_cmd(OP_CLEAR, 0, 0, '0);
        send_cmd(OP_QUERY, 0, 0, '0);
        send_cmd(OP_LOAD, 30, 30, 20'sd100);
        write_radius(2'd0);
        send_cmd(OP_QUERY, 31, 31, '0);    // no fill at radius zero
        write_radius(2'd2);
        send_cmd(OP_QUERY, 32, 32, '0);
        write_radius(2'd3);                // clamps to the largest ring
        send_cmd(OP_QUERY, 28, 32, '0);
    endtask

    // Loads cluster in a small window so neighbor searches hit often.
    task automatic test_random(input int count);
        int op_pick, u, v, bu, bv;
        bu = $urandom_range(0, GS-8);
        bv = $urandom_range(0, GS-8);
        for (int i = 0; i < count; i++) begin
            op_pick = $urandom_range(0, 99);
            if (op_pick < 3) bu = $urandom_range(0, GS-8);
            if (op_pick < 3) bv = $urandom_range(0, GS-8);
            if ($urandom_range(0, 9) == 0) begin
                u = $urandom_range(0, GS-1);
                v = $urandom_range(0, GS-1);
            end else begin
                u = bu + $urandom_range(0, 7);
                v = bv + $urandom_range(0, 7);
            end
            if (op_pick < 45)       send_cmd(OP_LOAD, u, v, rand_height());
            else if (op_pick < 96)  send_cmd(OP_QUERY, u, v, '0);
            else if (op_pick < 98)  send_cmd(OP_UNUSED, u, v, rand_height());
            else                    send_cmd(OP_CLEAR, u, v, '0);
        end
    endtask

    initial begin
        errors = 0; n_sent = 0; n_seen = 0; n_found = 0;
        cycles = 0; calm = 1'b0;
        radius_reg = FILL_RADIUS_RST;
        foreach (grid_ok[k]) grid_ok[k] = 1'b0;
        i_rst_n = 1'b0; i_cfg_we = 1'b0; i_cfg_data = '0;
        in_ch.valid = 1'b0; in_ch.op = OP_LOAD; in_ch.cell_u = '0;
        in_ch.cell_v = '0; in_ch.height = '0;
        out_ch.ready = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        write_radius(2'd1);
        test_random(350);
        write_radius(2'd2);
        test_random(350);
        write_radius(2'd0);
        test_random(150);
        calm = 1'b1;
        write_radius(2'd2);
        test_random(150);
        in_ch.valid <= 1'b0;
        while (lookups_due.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        $display("sent %0d commands, checked %0d lookups (%0d found)",
                 n_sent, n_seen, n_found);
        $display("fill radius swept over 0 to 3 with random stalls on both sides");
        if (errors == 0 && lookups_due.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

[grid_height_lookup_median_fill.f]
sv/ghl_pkg.sv
sv/ghl_ifs.sv
sv/ghl_ram.sv
sv/ghl_front.sv
sv/ghl_queue.sv
sv/ghl_back.sv
sv/grid_height_lookup_median_fill.sv
sv/ghl_checker.sv
tb/testbench.sv
